>>> hw/rtl/jtsc_pkg.sv
// ----------------------------------------------------------------------------
// jtsc_pkg
// Token, event, error and stack frame codes for the JSON token structure
// checker.
// ----------------------------------------------------------------------------
package jtsc_pkg;

  typedef enum logic [3:0] {
    TOK_LBRACE   = 4'd0,
    TOK_RBRACE   = 4'd1,
    TOK_LBRACKET = 4'd2,
    TOK_RBRACKET = 4'd3,
    TOK_COLON    = 4'd4,
    TOK_COMMA    = 4'd5,
    TOK_STRING   = 4'd6,
    TOK_NUMBER   = 4'd7,
    TOK_TRUE     = 4'd8,
    TOK_FALSE    = 4'd9,
    TOK_NULL     = 4'd10,
    TOK_LEX_ERR  = 4'd11,
    TOK_EOI      = 4'd12
  } token_kind_t;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_START_OBJ = 4'd1,
    EV_END_OBJ   = 4'd2,
    EV_START_ARR = 4'd3,
    EV_END_ARR   = 4'd4,
    EV_KEY       = 4'd5,
    EV_STRING    = 4'd6,
    EV_NUMBER    = 4'd7,
    EV_BOOLEAN   = 4'd8,
    EV_NULL      = 4'd9
  } event_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_UNEXPECTED = 3'd1,
    ERR_EARLY_END  = 3'd2,
    ERR_LEXER      = 3'd3,
    ERR_OVERFLOW   = 3'd4
  } error_kind_t;

  typedef enum logic [2:0] {
    EX_KEY_OR_END   = 3'd0,
    EX_COLON        = 3'd1,
    EX_VALUE        = 3'd2,
    EX_COMMA_OR_END = 3'd3,
    EX_VALUE_OR_END = 3'd4
  } expect_t;

  typedef struct packed {
    logic    is_array;
    expect_t ex;
  } frame_t;

  localparam int unsigned CFG_W      = 7;
  localparam int unsigned DETAIL_W   = 4;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 7'd64;

endpackage

>>> hw/rtl/json_token_structure_checker.sv
// ----------------------------------------------------------------------------
// json_token_structure_checker
// Checks a stream of lexed JSON tokens against the grammar with a pushdown
// stack of container frames and emits one structural event per token.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: token_kind; tdata: value_tag, lexer_code
//  m_*      out  m_tvalid/m_tready  tuser: event_kind; tdata: result fields
//  cfg_*    in   cfg_wen            cfg_wdata: depth_limit
//
//  One token per cycle while no result is held; each result is registered and appears in the cycle after its request.
//  The top frame and the frame below it sit in registers, the rest of the
//  stack in a memory with one write and one registered read port.
//  rst clears level, flags, error record and sets depth_limit to 64.
//  A stalled result holds and blocks the input only while it is not taken.
// ----------------------------------------------------------------------------
module json_token_structure_checker #(
  parameter int unsigned MAX_DEPTH = 64,
  parameter int unsigned TAG_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // value_tag, lexer_code
  input  logic [((TAG_WIDTH+4+7)/8)*8-1:0]        s_tdata,
  // token_kind
  input  logic [3:0]                              s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // bool_value, event_tag, error_flag, error_kind, error_detail, root_done
  output logic [((TAG_WIDTH+10+7)/8)*8-1:0]       m_tdata,
  // event_kind
  output logic [3:0]                              m_tuser,
  input  logic                                    cfg_wen,
  input  logic [jtsc_pkg::CFG_W-1:0]              cfg_wdata
);
  import jtsc_pkg::*;

  localparam int unsigned OUT_W  = ((TAG_WIDTH + 10 + 7) / 8) * 8;
  localparam int unsigned LVL_W  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_DEPTH);
  localparam int unsigned CMP_W  = (LVL_W > CFG_W) ? LVL_W : CFG_W;

  frame_t                 mem [MAX_DEPTH];
  frame_t                 top;
  frame_t                 under;
  logic [LVL_W-1:0]       level;
  logic                   root_finished;
  logic                   error_seen;
  error_kind_t            err_kind;
  logic [DETAIL_W-1:0]    err_detail;
  logic [CFG_W-1:0]       depth_limit;

  token_kind_t            tok;
  logic [TAG_WIDTH-1:0]   in_tag;
  logic [DETAIL_W-1:0]    in_code;
  logic                   accept;

  event_kind_t            ev;
  logic                   ev_bool;
  logic [TAG_WIDTH-1:0]   ev_tag;
  logic                   set_err;
  error_kind_t            new_kind;
  logic [DETAIL_W-1:0]    new_detail;
  logic                   push;
  logic                   pop;
  frame_t                 push_frame;
  frame_t                 top_upd;
  logic                   root_set;
  logic                   take;
  logic [CMP_W-1:0]       lim;
  logic                   at_limit;
  logic [LVL_W-1:0]       lvl_m1;
  logic [LVL_W-1:0]       lvl_m3;

  logic                   error_seen_next;
  error_kind_t            err_kind_next;
  logic [DETAIL_W-1:0]    err_detail_next;
  logic                   root_finished_next;

  assign tok     = token_kind_t'(s_tuser);
  assign in_tag  = s_tdata[TAG_WIDTH-1:0];
  assign in_code = s_tdata[TAG_WIDTH+DETAIL_W-1:TAG_WIDTH];
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign lvl_m1 = level - LVL_W'(1);
  assign lvl_m3 = level - LVL_W'(3);

  always_comb begin
    if (CMP_W'(depth_limit) > CMP_W'(MAX_DEPTH)) begin
      lim = CMP_W'(MAX_DEPTH);
    end else begin
      lim = CMP_W'(depth_limit);
    end
    at_limit = CMP_W'(level) >= lim;
  end

  always_comb begin
    ev         = EV_NONE;
    ev_bool    = 1'b0;
    ev_tag     = '0;
    set_err    = 1'b0;
    new_kind   = ERR_UNEXPECTED;
    new_detail = '0;
    push       = 1'b0;
    pop        = 1'b0;
    push_frame = top;
    top_upd    = top;
    root_set   = 1'b0;
    take       = 1'b0;

    if (!error_seen) begin
      if (tok == TOK_LEX_ERR) begin
        set_err = 1'b1;
        if (in_code != '0) begin
          new_kind   = ERR_LEXER;
          new_detail = in_code;
        end
      end else if (tok == TOK_EOI) begin
        if (!root_finished || level != '0) begin
          set_err  = 1'b1;
          new_kind = ERR_EARLY_END;
        end
      end else if (level == '0) begin
        if (root_finished) begin
          set_err = 1'b1;
        end else begin
          take = 1'b1;
        end
      end else if (!top.is_array) begin
        if ((top.ex == EX_KEY_OR_END || top.ex == EX_COMMA_OR_END) && tok == TOK_RBRACE) begin
          ev  = EV_END_OBJ;
          pop = 1'b1;
        end else if (top.ex == EX_KEY_OR_END && tok == TOK_STRING) begin
          ev         = EV_KEY;
          ev_tag     = in_tag;
          top_upd.ex = EX_COLON;
        end else if (top.ex == EX_COLON && tok == TOK_COLON) begin
          top_upd.ex = EX_VALUE;
        end else if (top.ex == EX_VALUE) begin
          top_upd.ex = EX_COMMA_OR_END;
          take       = 1'b1;
        end else if (top.ex == EX_COMMA_OR_END && tok == TOK_COMMA) begin
          top_upd.ex = EX_KEY_OR_END;
        end else begin
          set_err = 1'b1;
        end
      end else begin
        if ((top.ex == EX_VALUE_OR_END || top.ex == EX_COMMA_OR_END) && tok == TOK_RBRACKET) begin
          ev  = EV_END_ARR;
          pop = 1'b1;
        end else if (top.ex == EX_VALUE_OR_END) begin
          top_upd.ex = EX_COMMA_OR_END;
          take       = 1'b1;
        end else if (top.ex == EX_COMMA_OR_END && tok == TOK_COMMA) begin
          top_upd.ex = EX_VALUE_OR_END;
        end else begin
          set_err = 1'b1;
        end
      end

      if (pop && level == LVL_W'(1)) begin
        root_set = 1'b1;
      end

      if (take) begin
        case (tok)
          TOK_LBRACE, TOK_LBRACKET: begin
            if (at_limit) begin
              set_err  = 1'b1;
              new_kind = ERR_OVERFLOW;
            end else begin
              push = 1'b1;
              if (tok == TOK_LBRACE) begin
                ev         = EV_START_OBJ;
                push_frame = '{is_array: 1'b0, ex: EX_KEY_OR_END};
              end else begin
                ev         = EV_START_ARR;
                push_frame = '{is_array: 1'b1, ex: EX_VALUE_OR_END};
              end
            end
          end
          TOK_STRING: begin
            ev     = EV_STRING;
            ev_tag = in_tag;
          end
          TOK_NUMBER: begin
            ev     = EV_NUMBER;
            ev_tag = in_tag;
          end
          TOK_TRUE: begin
            ev      = EV_BOOLEAN;
            ev_bool = 1'b1;
          end
          TOK_FALSE: ev = EV_BOOLEAN;
          TOK_NULL:  ev = EV_NULL;
          default:   set_err = 1'b1;
        endcase
        if (!set_err && !push && level == '0) begin
          root_set = 1'b1;
        end
      end
    end

    error_seen_next    = error_seen || set_err;
    err_kind_next      = set_err ? new_kind : err_kind;
    err_detail_next    = set_err ? new_detail : err_detail;
    root_finished_next = root_finished || root_set;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= '0;
      root_finished <= 1'b0;
      error_seen    <= 1'b0;
      err_kind      <= ERR_NONE;
      err_detail    <= '0;
      depth_limit   <= LIMIT_RESET;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_wen) begin
        depth_limit <= cfg_wdata;
      end
      if (accept) begin
        error_seen    <= error_seen_next;
        err_kind      <= err_kind_next;
        err_detail    <= err_detail_next;
        root_finished <= root_finished_next;
        if (push) begin
          level <= level + LVL_W'(1);
        end else if (pop) begin
          level <= lvl_m1;
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (push) begin
        if (level != '0) begin
          mem[lvl_m1[ADDR_W-1:0]] <= top_upd;
        end
        under <= top_upd;
        top   <= push_frame;
      end else if (pop) begin
        top   <= under;
        under <= mem[lvl_m3[ADDR_W-1:0]];
      end else begin
        top <= top_upd;
      end
      m_tuser <= ev;
      m_tdata <= OUT_W'({root_finished_next, err_detail_next, err_kind_next,
                         error_seen_next, ev_tag, ev_bool});
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON token structure checker. Streams one long
// well-formed document of random content through the token port, under
// several depth limits up to the full stack, with bursty requests and a
// receiver that stalls and holds off. The run ends with one error case
// chosen at random, followed by tokens that must be ignored. Every event is
// compared field by field against a local pushdown grammar tracker.
// ----------------------------------------------------------------------------
module tb;
  import jtsc_pkg::*;

  localparam int TAG_W   = 16;
  localparam int MAX_LVL = 64;
  localparam int S_W     = ((TAG_W + 4 + 7) / 8) * 8;
  localparam int M_W     = ((TAG_W + 10 + 7) / 8) * 8;

  typedef struct {
    logic [3:0]       kind;
    logic [TAG_W-1:0] tag;
    logic [3:0]       code;
  } token_t;

  typedef struct {
    event_kind_t      ev;
    logic             bool_v;
    logic [TAG_W-1:0] tag;
    logic             err;
    error_kind_t      ek;
    logic [3:0]       det;
    logic             rdone;
  } outcome_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [S_W-1:0]   s_tdata = '0;   // value_tag, lexer_code
  logic [3:0]       s_tuser = '0;   // token_kind
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [M_W-1:0]   m_tdata;        // bool_value, event_tag, error_flag, error_kind,
                                    // error_detail, root_done
  logic [3:0]       m_tuser;        // event_kind
  logic             cfg_wen = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  token_t   token_q[$];
  outcome_t result_q[$];
  int       fails = 0;
  int       n_made = 0;
  bit       req_taken = 1'b0;
  int       burst_left = 1;
  int       gap_left = 0;
  int       rx_cyc = 0;
  int       hold_left = 0;
  int       holds = 0;

  // grammar tracker state
  frame_t           stk [MAX_LVL];
  int unsigned      lvl = 0;
  logic             root_fin = 1'b0;
  logic             err_on = 1'b0;
  error_kind_t      err_k = ERR_NONE;
  logic [3:0]       err_d = '0;
  logic [CFG_W-1:0] limit_cur = LIMIT_RESET;
  event_kind_t      ev_k;
  logic             ev_b;
  logic [TAG_W-1:0] ev_t;

  json_token_structure_checker #(
    .MAX_DEPTH(MAX_LVL),
    .TAG_WIDTH(TAG_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void flag_error(error_kind_t k, logic [3:0] d);
    if (!err_on) begin
      err_on = 1'b1;
      err_k  = k;
      err_d  = d;
    end
  endfunction

  function automatic void open_container(bit arr, expect_t ex, event_kind_t ev);
    int unsigned cap;
    cap = (limit_cur > MAX_LVL) ? MAX_LVL : limit_cur;
    if (lvl >= cap) begin
      flag_error(ERR_OVERFLOW, 4'd0);
    end else begin
      stk[lvl].is_array = arr;
      stk[lvl].ex = ex;
      lvl++;
      ev_k = ev;
    end
  endfunction

  function automatic void close_container(event_kind_t ev);
    ev_k = ev;
    if (lvl > 0) lvl--;
    if (lvl == 0) root_fin = 1'b1;
  endfunction

  function automatic bit take_value(logic [3:0] k, logic [TAG_W-1:0] tag);
    bit ok;
    ok = 1'b1;
    case (k)
      TOK_LBRACE:   open_container(1'b0, EX_KEY_OR_END, EV_START_OBJ);
      TOK_LBRACKET: open_container(1'b1, EX_VALUE_OR_END, EV_START_ARR);
      TOK_STRING: begin
        ev_k = EV_STRING;
        ev_t = tag;
      end
      TOK_NUMBER: begin
        ev_k = EV_NUMBER;
        ev_t = tag;
      end
      TOK_TRUE: begin
        ev_k = EV_BOOLEAN;
        ev_b = 1'b1;
      end
      TOK_FALSE: ev_k = EV_BOOLEAN;
      TOK_NULL:  ev_k = EV_NULL;
      default:   ok = 1'b0;
    endcase
    if (ok && k != TOK_LBRACE && k != TOK_LBRACKET && lvl == 0) root_fin = 1'b1;
    return ok;
  endfunction

  function automatic outcome_t parse_token(token_t t);
    outcome_t    o;
    int unsigned top;
    frame_t      fr;
    ev_k = EV_NONE;
    ev_b = 1'b0;
    ev_t = '0;
    if (!err_on) begin
      if (t.kind == TOK_LEX_ERR) begin
        if (t.code != 4'd0) flag_error(ERR_LEXER, t.code);
        else flag_error(ERR_UNEXPECTED, 4'd0);
      end else if (t.kind == TOK_EOI) begin
        if (!root_fin || lvl != 0) flag_error(ERR_EARLY_END, 4'd0);
      end else if (lvl == 0) begin
        if (root_fin || !take_value(t.kind, t.tag)) flag_error(ERR_UNEXPECTED, 4'd0);
      end else begin
        top = lvl - 1;
        fr = stk[top];
        if (!fr.is_array) begin
          if (fr.ex == EX_KEY_OR_END && t.kind == TOK_RBRACE) begin
            close_container(EV_END_OBJ);
          end else if (fr.ex == EX_KEY_OR_END && t.kind == TOK_STRING) begin
            ev_k = EV_KEY;
            ev_t = t.tag;
            stk[top].ex = EX_COLON;
          end else if (fr.ex == EX_COLON && t.kind == TOK_COLON) begin
            stk[top].ex = EX_VALUE;
          end else if (fr.ex == EX_VALUE) begin
            stk[top].ex = EX_COMMA_OR_END;
            if (!take_value(t.kind, t.tag)) flag_error(ERR_UNEXPECTED, 4'd0);
          end else if (fr.ex == EX_COMMA_OR_END && t.kind == TOK_COMMA) begin
            stk[top].ex = EX_KEY_OR_END;
          end else if (fr.ex == EX_COMMA_OR_END && t.kind == TOK_RBRACE) begin
            close_container(EV_END_OBJ);
          end else begin
            flag_error(ERR_UNEXPECTED, 4'd0);
          end
        end else begin
          if (fr.ex == EX_VALUE_OR_END && t.kind == TOK_RBRACKET) begin
            close_container(EV_END_ARR);
          end else if (fr.ex == EX_VALUE_OR_END) begin
            stk[top].ex = EX_COMMA_OR_END;
            if (!take_value(t.kind, t.tag)) flag_error(ERR_UNEXPECTED, 4'd0);
          end else if (fr.ex == EX_COMMA_OR_END && t.kind == TOK_COMMA) begin
            stk[top].ex = EX_VALUE_OR_END;
          end else if (fr.ex == EX_COMMA_OR_END && t.kind == TOK_RBRACKET) begin
            close_container(EV_END_ARR);
          end else begin
            flag_error(ERR_UNEXPECTED, 4'd0);
          end
        end
      end
    end
    o.ev     = ev_k;
    o.bool_v = ev_b;
    o.tag    = ev_t;
    o.err    = err_on;
    o.ek     = err_k;
    o.det    = err_d;
    o.rdone  = root_fin;
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  // sender: bursts of requests with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (token_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tuser  <= token_q[0].kind;
        s_tdata  <= {{(S_W-TAG_W-4){1'b0}}, token_q[0].code, token_q[0].tag};
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: long hold-offs while requests are queued, otherwise a stall
  // pattern that rotates
  always @(negedge clk) begin
    rx_cyc++;
    if (hold_left == 0 && holds < 2 && rx_cyc >= 300 * (holds + 1) &&
        token_q.size() > 8) begin
      hold_left = (holds == 0) ? 80 : 120;
      holds++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case ((rx_cyc / 200) % 4)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 9) < 7);
        2:       m_tready <= ($urandom_range(0, 9) < 3);
        default: m_tready <= (rx_cyc % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin : observe
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t: event with no request pending, expected none, actual event_kind %0h",
                 $time, m_tuser);
        fails++;
      end else begin
        want = result_q.pop_front();
        check_field("event_kind", 32'(want.ev), 32'(m_tuser));
        check_field("bool_value", 32'(want.bool_v), 32'(m_tdata[0]));
        check_field("event_tag", 32'(want.tag), 32'(m_tdata[TAG_W:1]));
        check_field("error_flag", 32'(want.err), 32'(m_tdata[TAG_W+1]));
        check_field("error_kind", 32'(want.ek), 32'(m_tdata[TAG_W+4:TAG_W+2]));
        check_field("error_detail", 32'(want.det), 32'(m_tdata[TAG_W+8:TAG_W+5]));
        check_field("root_done", 32'(want.rdone), 32'(m_tdata[TAG_W+9]));
      end
    end
    req_taken = !rst && s_tvalid && s_tready;
    if (req_taken) result_q = {result_q, parse_token(token_q.pop_front())};
  end

  task automatic put_tok(logic [3:0] k, logic [TAG_W-1:0] tag, logic [3:0] code);
    token_t t;
    t.kind = k;
    t.tag  = tag;
    t.code = code;
    token_q = {token_q, t};
    n_made++;
  endtask

  task automatic put(logic [3:0] k);
    put_tok(k, TAG_W'($urandom_range(0, (1 << TAG_W) - 1)), 4'($urandom_range(0, 15)));
  endtask

  task automatic put_scalar();
    case ($urandom_range(0, 4))
      0:       put(TOK_STRING);
      1:       put(TOK_NUMBER);
      2:       put(TOK_TRUE);
      3:       put(TOK_FALSE);
      default: put(TOK_NULL);
    endcase
  endtask

  // emit one well-formed value; base is the stack level it starts at
  task automatic emit_value(int base, int cap, bit deep);
    bit arr_of [MAX_LVL];
    bit first  [MAX_LVL];
    int left   [MAX_LVL];
    int d;
    bit need;
    d = 0;
    need = 1'b1;
    while (need || d > 0) begin
      if (need) begin
        need = 1'b0;
        if (base + d < cap && (deep || (base + d < 8 && $urandom_range(0, 9) < 3))) begin
          arr_of[d] = 1'($urandom_range(0, 1));
          put(arr_of[d] ? TOK_LBRACKET : TOK_LBRACE);
          left[d]  = deep ? 1 : $urandom_range(0, 3);
          first[d] = 1'b1;
          d++;
        end else begin
          put_scalar();
        end
      end else if (left[d-1] == 0) begin
        put(arr_of[d-1] ? TOK_RBRACKET : TOK_RBRACE);
        d--;
      end else begin
        left[d-1]--;
        if (!first[d-1]) put(TOK_COMMA);
        first[d-1] = 1'b0;
        if (!arr_of[d-1]) begin
          put(TOK_STRING);
          put(TOK_COLON);
        end
        need = 1'b1;
      end
    end
  endtask

  task automatic wait_idle();
    while (token_q.size() != 0 || result_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    limit_cur = v;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] lim, int count);
    int cap;
    int stop;
    wait_idle();
    write_limit(lim);
    cap = (lim > MAX_LVL) ? MAX_LVL : lim;
    stop = n_made + count;
    while (n_made < stop) begin
      put(TOK_COMMA);
      emit_value(1, cap, cap > 1 && $urandom_range(0, 11) == 0);
    end
  endtask

  initial begin : stimulus
    int fin;
    int k;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // root array holding empty containers, keys, tag extremes and every scalar
    put(TOK_LBRACKET);
    put(TOK_LBRACE);
    put(TOK_RBRACE);
    put(TOK_COMMA);
    put(TOK_LBRACKET);
    put(TOK_RBRACKET);
    put(TOK_COMMA);
    put(TOK_LBRACE);
    put_tok(TOK_STRING, '0, 4'd0);
    put(TOK_COLON);
    put_tok(TOK_STRING, '1, 4'hF);
    put(TOK_COMMA);
    put_tok(TOK_STRING, '1, 4'd0);
    put(TOK_COLON);
    put_tok(TOK_NUMBER, '0, 4'hF);
    put(TOK_COMMA);
    put(TOK_STRING);
    put(TOK_COLON);
    put(TOK_LBRACKET);
    put(TOK_TRUE);
    put(TOK_RBRACKET);
    put(TOK_RBRACE);
    put(TOK_COMMA);
    put(TOK_FALSE);
    put(TOK_COMMA);
    put(TOK_NULL);

    run_phase(7'd127, 190);
    run_phase(7'd1, 190);
    run_phase(7'd64, 190);
    run_phase(7'($urandom_range(2, 63)), 190);
    run_phase(7'd2, 190);
    run_phase(7'($urandom_range(0, 127)), 190);

    fin = $urandom_range(0, 6);
    case (fin)
      0: begin
        put(TOK_RBRACKET);
        put(TOK_EOI);
        put(4'($urandom_range(0, 15)));
      end
      1: put(TOK_EOI);
      2: put_tok(TOK_LEX_ERR, TAG_W'($urandom_range(0, (1 << TAG_W) - 1)),
                 4'($urandom_range(1, 15)));
      3: put_tok(TOK_LEX_ERR, TAG_W'($urandom_range(0, (1 << TAG_W) - 1)), 4'd0);
      4: put(4'($urandom_range(13, 15)));
      5: begin
        wait_idle();
        write_limit(7'($urandom_range(0, 3)));
        put(TOK_COMMA);
        repeat (6) put(TOK_LBRACKET);
      end
      default: begin
        put(TOK_COMMA);
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 2))
            0:       put(TOK_COLON);
            1:       put(TOK_COMMA);
            default: put(TOK_RBRACE);
          endcase
        end else begin
          put(TOK_LBRACE);
          k = $urandom_range(2, 10);
          put(4'(k == TOK_STRING ? TOK_NUMBER : k));
        end
      end
    endcase
    repeat (30) put(4'($urandom_range(0, 15)));

    wait_idle();
    repeat (10) @(negedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
